// ----- rtl/b58_pkg.sv -----
// ----------------------------------------------------------------------------
// b58_pkg
// Shared types, constants and the character map of the base-58 encoder.
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int DIGIT_DEPTH = 45;
    localparam int DIGIT_W     = 6;
    localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = 6;
    localparam int TOTAL_W     = CNT_W + 1;
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int RADIX       = 58;
    // floor(v * RECIP / 2^RECIP_SH) == floor(v / 58) for every v below 58 * 256
    localparam int RECIP       = 1130;
    localparam int RECIP_SH    = 16;
    localparam int VAL_W       = DIGIT_W + BYTE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_SPILL,
        ST_CHECK,
        ST_EMIT_ZERO,
        ST_EMIT_DIGIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        unique case (d)
            6'd0:  c = "1";  6'd1:  c = "2";  6'd2:  c = "3";  6'd3:  c = "4";
            6'd4:  c = "5";  6'd5:  c = "6";  6'd6:  c = "7";  6'd7:  c = "8";
            6'd8:  c = "9";  6'd9:  c = "A";  6'd10: c = "B";  6'd11: c = "C";
            6'd12: c = "D";  6'd13: c = "E";  6'd14: c = "F";  6'd15: c = "G";
            6'd16: c = "H";  6'd17: c = "J";  6'd18: c = "K";  6'd19: c = "L";
            6'd20: c = "M";  6'd21: c = "N";  6'd22: c = "P";  6'd23: c = "Q";
            6'd24: c = "R";  6'd25: c = "S";  6'd26: c = "T";  6'd27: c = "U";
            6'd28: c = "V";  6'd29: c = "W";  6'd30: c = "X";  6'd31: c = "Y";
            6'd32: c = "Z";  6'd33: c = "a";  6'd34: c = "b";  6'd35: c = "c";
            6'd36: c = "d";  6'd37: c = "e";  6'd38: c = "f";  6'd39: c = "g";
            6'd40: c = "h";  6'd41: c = "i";  6'd42: c = "j";  6'd43: c = "k";
            6'd44: c = "m";  6'd45: c = "n";  6'd46: c = "o";  6'd47: c = "p";
            6'd48: c = "q";  6'd49: c = "r";  6'd50: c = "s";  6'd51: c = "t";
            6'd52: c = "u";  6'd53: c = "v";  6'd54: c = "w";  6'd55: c = "x";
            6'd56: c = "y";  6'd57: c = "z";
            default: c = 8'd0;
        endcase
        return c[CHAR_W-1:0];
    endfunction

endpackage

// ----- rtl/base58_encoder.sv -----
// ----------------------------------------------------------------------------
// base58_encoder
// Byte-serial base-58 encoder with the Bitcoin alphabet.
// ----------------------------------------------------------------------------
// A byte is taken on a clock edge where start is high and busy is low;
// i_final_byte marks the last byte of a message. Leading zero bytes are only
// counted. Every later byte runs a carry pass over the stored digits, one
// digit per cycle through a single divide-by-58 unit, followed by a spill
// step for each new digit the carry spills into and one closing step.
// After the final byte comes a check state, then one character per cycle
// on o_out_char with o_valid high: a '1' per leading zero byte, then the
// digits most significant first; o_last_char marks the last one. A message
// beyond capacity yields one beat with o_too_long and o_last_char set and
// o_out_char zero. Results cannot be held off; busy stays high until the
// last beat is issued. Reset clears the message state; the digit RAM holds
// no reset and only digits already written are used.
// ----------------------------------------------------------------------------
module base58_encoder #(
    parameter int MAX_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [b58_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_final_byte,
    output logic                        o_valid,
    output logic [b58_pkg::CHAR_W-1:0]  o_out_char,
    output logic                        o_last_char,
    output logic                        o_too_long
);
    import b58_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_digit_cnt, n_digit_cnt;
    logic [CNT_W-1:0]   r_zero_cnt, n_zero_cnt;
    logic               r_in_lz, n_in_lz;
    logic [CNT_W-1:0]   r_byte_cnt, n_byte_cnt;
    logic               r_ovf, n_ovf;
    logic               r_final, n_final;
    logic [BYTE_W-1:0]  r_carry, n_carry;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_err, n_err;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DIGIT_W-1:0] rd_data;
    logic [DIGIT_W-1:0] dm_digit;
    logic [DIGIT_W-1:0] dm_rem;
    logic [BYTE_W-1:0]  dm_quot;

    logic               acc;
    logic               take;
    logic               drop;
    logic               is_zero;
    logic               do_fold;
    logic               last_fold;
    logic               spill_done;
    logic [TOTAL_W-1:0] total;
    logic               msg_err;
    logic [CNT_W-1:0]   top_idx;

    assign acc       = start && (r_state == ST_IDLE);
    assign take      = acc && !r_ovf && (r_byte_cnt < CNT_W'(MAX_BYTES));
    assign drop      = acc && !r_ovf && !(r_byte_cnt < CNT_W'(MAX_BYTES));
    assign is_zero   = take && r_in_lz && (i_data_byte == '0);
    assign do_fold   = take && !is_zero;
    assign last_fold = (r_idx == r_digit_cnt - CNT_W'(1));
    assign spill_done = (r_carry == '0) || (r_digit_cnt >= CNT_W'(DIGIT_DEPTH));
    assign total     = TOTAL_W'(r_zero_cnt) + TOTAL_W'(r_digit_cnt);
    assign msg_err   = r_ovf || (total > TOTAL_W'(DIGIT_DEPTH)) || (total == '0);
    assign top_idx   = (r_digit_cnt != '0) ? r_digit_cnt - CNT_W'(1) : '0;

    // during the spill the stored digit is absent
    assign dm_digit = (r_state == ST_FOLD) ? rd_data : '0;

    b58_divmod u_divmod (
        .i_digit (dm_digit),
        .i_carry (r_carry),
        .o_rem   (dm_rem),
        .o_quot  (dm_quot)
    );

    b58_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (dm_rem),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (do_fold) begin
                        n_state = (r_digit_cnt == '0) ? ST_SPILL : ST_FOLD;
                    end else if (i_final_byte) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_FOLD: begin
                if (last_fold) begin
                    n_state = ST_SPILL;
                end
            end
            ST_SPILL: begin
                if (spill_done) begin
                    n_state = r_final ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (msg_err) begin
                    n_state = ST_IDLE;
                end else if (r_zero_cnt != '0) begin
                    n_state = ST_EMIT_ZERO;
                end else begin
                    n_state = ST_EMIT_DIGIT;
                end
            end
            ST_EMIT_ZERO: begin
                if (r_idx == r_zero_cnt - CNT_W'(1)) begin
                    n_state = (r_digit_cnt == '0) ? ST_IDLE : ST_EMIT_DIGIT;
                end
            end
            ST_EMIT_DIGIT: begin
                if (r_idx == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        logic clear;
        clear       = 1'b0;
        n_digit_cnt = r_digit_cnt;
        n_zero_cnt  = r_zero_cnt;
        n_in_lz     = r_in_lz;
        n_byte_cnt  = r_byte_cnt;
        n_ovf       = r_ovf;
        n_final     = r_final;
        n_carry     = r_carry;
        n_idx       = r_idx;
        n_valid     = 1'b0;
        n_char      = '0;
        n_last      = 1'b0;
        n_err       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_idx[ADDR_W-1:0];
        rd_addr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_final = i_final_byte;
                    if (drop) begin
                        n_ovf = 1'b1;
                    end
                    if (take) begin
                        n_byte_cnt = r_byte_cnt + CNT_W'(1);
                    end
                    if (is_zero) begin
                        n_zero_cnt = r_zero_cnt + CNT_W'(1);
                    end
                    if (do_fold) begin
                        n_in_lz = 1'b0;
                        n_carry = i_data_byte;
                        n_idx   = '0;
                    end
                end
            end
            ST_FOLD: begin
                // write back digit idx, fetch digit idx+1
                wr_en   = 1'b1;
                n_carry = dm_quot;
                n_idx   = r_idx + CNT_W'(1);
                if (!last_fold) begin
                    rd_addr = n_idx[ADDR_W-1:0];
                end
            end
            ST_SPILL: begin
                if (r_carry != '0) begin
                    if (r_digit_cnt >= CNT_W'(DIGIT_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = r_digit_cnt[ADDR_W-1:0];
                        n_digit_cnt = r_digit_cnt + CNT_W'(1);
                        n_carry     = dm_quot;
                    end
                end
            end
            ST_CHECK: begin
                rd_addr = top_idx[ADDR_W-1:0];
                if (msg_err) begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    n_err   = 1'b1;
                    clear   = 1'b1;
                end else if (r_zero_cnt != '0) begin
                    n_idx = '0;
                end else begin
                    n_idx = top_idx;
                end
            end
            ST_EMIT_ZERO: begin
                rd_addr = top_idx[ADDR_W-1:0];
                n_valid = 1'b1;
                n_char  = digit_char('0);
                n_idx   = r_idx + CNT_W'(1);
                if (r_idx == r_zero_cnt - CNT_W'(1)) begin
                    n_idx = top_idx;
                    if (r_digit_cnt == '0) begin
                        n_last = 1'b1;
                        clear  = 1'b1;
                    end
                end
            end
            ST_EMIT_DIGIT: begin
                n_valid = 1'b1;
                n_char  = digit_char(rd_data);
                n_idx   = r_idx - CNT_W'(1);
                if (r_idx == '0) begin
                    n_last = 1'b1;
                    clear  = 1'b1;
                end else begin
                    rd_addr = n_idx[ADDR_W-1:0];
                end
            end
            default: begin
                clear = 1'b1;
            end
        endcase

        if (clear) begin
            n_digit_cnt = '0;
            n_zero_cnt  = '0;
            n_in_lz     = 1'b1;
            n_byte_cnt  = '0;
            n_ovf       = 1'b0;
            n_final     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_digit_cnt <= '0;
            r_zero_cnt  <= '0;
            r_in_lz     <= 1'b1;
            r_byte_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_final     <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_digit_cnt <= n_digit_cnt;
            r_zero_cnt  <= n_zero_cnt;
            r_in_lz     <= n_in_lz;
            r_byte_cnt  <= n_byte_cnt;
            r_ovf       <= n_ovf;
            r_final     <= n_final;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_char  <= n_char;
        r_last  <= n_last;
        r_err   <= n_err;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;
    assign o_too_long  = r_err;

endmodule

// ----- rtl/b58_ram.sv -----
// ----------------------------------------------------------------------------
// b58_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b58_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 45
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/b58_divmod.sv -----
// ----------------------------------------------------------------------------
// b58_divmod
// Carry step: (digit * 256 + carry) split into quotient and remainder by 58.
// ----------------------------------------------------------------------------
module b58_divmod
(
    input  logic [b58_pkg::DIGIT_W-1:0] i_digit,
    input  logic [b58_pkg::BYTE_W-1:0]  i_carry,
    output logic [b58_pkg::DIGIT_W-1:0] o_rem,
    output logic [b58_pkg::BYTE_W-1:0]  o_quot
);
    import b58_pkg::*;

    localparam int PROD_W = VAL_W + $clog2(RECIP + 1);

    logic [VAL_W-1:0]  value;
    logic [PROD_W-1:0] prod;
    logic [BYTE_W-1:0] quot;
    logic [VAL_W-1:0]  quot_x58;
    logic [VAL_W-1:0]  rem_full;

    // reciprocal multiply, exact for every digit below 58 and any carry
    assign value    = {i_digit, i_carry};
    assign prod     = PROD_W'(value) * PROD_W'(RECIP);
    assign quot     = prod[RECIP_SH +: BYTE_W];
    assign quot_x58 = (VAL_W'(quot) << 6) - (VAL_W'(quot) << 3) + (VAL_W'(quot) << 1);
    assign rem_full = value - quot_x58;

    assign o_quot = quot;
    assign o_rem  = rem_full[DIGIT_W-1:0];

endmodule

// ----- rtl/b58_checker.sv -----
// ----------------------------------------------------------------------------
// b58_checker
// Port-level checks on the base-58 encoder result beats.
// ----------------------------------------------------------------------------
module b58_checker
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_valid,
    input  logic [b58_pkg::CHAR_W-1:0]  o_out_char,
    input  logic                        o_last_char,
    input  logic                        o_too_long
);
    import b58_pkg::*;

    // the error beat is a string of its own
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_long) |-> (o_last_char && (o_out_char == '0)))
        else $error("error beat not marked last or carries a character");

    // characters of one string come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_char) |=> o_valid)
        else $error("gap inside an output string");

    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_char) |-> busy)
        else $error("encoder idle while a string is still being sent");

    // an accepted byte never produces a beat on the next edge
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result beat right after an accepted byte");

endmodule

bind base58_encoder b58_checker u_b58_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char),
    .o_too_long  (o_too_long)
);
